// ----- hdl/rcs_pkg.sv -----
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants and types of the raycaster column setup pipeline.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int TEX_SIZE_DEF = 64;
    localparam int H_W          = 12;
    localparam int Q_W          = 32;
    localparam int LH_W         = 16;
    localparam int HALF_LH_W    = 15;
    localparam int COL_W        = 6;

    localparam logic [H_W-1:0] H_RESET = 12'd480;

    typedef struct packed {
        logic [LH_W-1:0]      line_height;
        logic [H_W-1:0]       draw_start;
        logic [H_W-1:0]       draw_end;
        logic [HALF_LH_W-1:0] start_ofs;
        logic                 degenerate;
    } slice_t;

endpackage

// ----- hdl/raycast_column_setup_top.sv -----
// ----------------------------------------------------------------------------
// raycast_column_setup_top
// Wall column setup for a grid raycaster: slice height, draw range, texture
// column, texture step and start position for one screen column per transfer.
// ----------------------------------------------------------------------------
// The block takes one column per clock while the output is not stalled
// and returns its result through 14 stages of the height divider, one
// slice stage, the (clog2(TEX_SIZE+1)+17)/2 stages of the step divider and
// one output stage. Both dividers retire two quotient bits per stage. A
// stalled output holds the whole pipeline; write screen_height only while
// no column is in flight.
// ----------------------------------------------------------------------------
module raycast_column_setup_top #(
    parameter int TEX_SIZE = rcs_pkg::TEX_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata,      // screen_height
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, ray_dir_x, ray_dir_y, perp_dist
    input  logic [159:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,   // hit_side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // line_height, draw_start, draw_end, tex_col, tex_step, tex_start, pad
    output logic [111:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // degenerate
);

    localparam int NW1 = 28;
    localparam int S1  = (NW1 + 1) / 2;
    localparam int NW2 = $clog2(TEX_SIZE + 1) + 16;
    localparam int S2  = (NW2 + 1) / 2;
    localparam int LAT = S1 + S2 + 2;
    localparam logic [NW2-1:0] TEX_NUM = NW2'(TEX_SIZE) << 16;

    logic [rcs_pkg::H_W-1:0] h_reg;
    logic [LAT-1:0]          vld_reg;
    logic                    en;

    logic [31:0] perp_dist;
    logic [NW1-1:0] q1;
    logic           dz;

    logic [rcs_pkg::COL_W-1:0] col_w;
    logic [rcs_pkg::COL_W-1:0] col_d;

    logic [rcs_pkg::LH_W-1:0]      lh;
    logic [rcs_pkg::H_W-2:0]       half_h;
    logic [rcs_pkg::HALF_LH_W-1:0] half_lh;
    logic [15:0]                   end_v;
    rcs_pkg::slice_t               slice_next;
    rcs_pkg::slice_t               slice_reg;
    rcs_pkg::slice_t               slice_d;

    logic [NW2-1:0] q2;
    logic [31:0]    step;
    logic [46:0]    start_full;

    logic [31:0]     step_reg;
    logic [31:0]     start_reg;
    rcs_pkg::slice_t out_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign perp_dist     = s_axis_tdata[159:128];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= rcs_pkg::H_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                h_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            end
        end
    end

    rcs_udiv #(.NW(NW1), .DW(32)) u_div_height (
        .clk (clk),
        .en  (en),
        .num ({h_reg, 16'd0}),
        .den (perp_dist),
        .quo (q1)
    );

    rcs_delay #(.W(1), .DEPTH(S1)) u_dly_zero (
        .clk  (clk),
        .en   (en),
        .din  (perp_dist == 32'd0),
        .dout (dz)
    );

    rcs_wall #(.TEX_SIZE(TEX_SIZE)) u_wall (
        .clk       (clk),
        .en        (en),
        .hit_side  (s_axis_tuser[0]),
        .pos_x     (s_axis_tdata[31:0]),
        .pos_y     (s_axis_tdata[63:32]),
        .ray_dir_x (s_axis_tdata[95:64]),
        .ray_dir_y (s_axis_tdata[127:96]),
        .perp_dist (perp_dist),
        .tex_col   (col_w)
    );

    rcs_delay #(.W(rcs_pkg::COL_W), .DEPTH(LAT-2)) u_dly_col (
        .clk  (clk),
        .en   (en),
        .din  (col_w),
        .dout (col_d)
    );

    // slice height and draw range
    assign lh      = (dz || (q1[NW1-1:16] != '0)) ? 16'hFFFF : q1[15:0];
    assign half_h  = h_reg[rcs_pkg::H_W-1:1];
    assign half_lh = lh[15:1];
    assign end_v   = 16'(half_lh) + 16'(half_h);

    always_comb
    begin
        slice_next.line_height = lh;
        slice_next.degenerate  = dz || (lh == 16'd0);
        if (15'(half_h) > half_lh)
        begin
            slice_next.draw_start = 12'(15'(half_h) - half_lh);
            slice_next.start_ofs  = '0;
        end
        else
        begin
            slice_next.draw_start = '0;
            slice_next.start_ofs  = half_lh - 15'(half_h);
        end
        if (end_v >= 16'(h_reg))
        begin
            slice_next.draw_end = (h_reg == '0) ? '0 : h_reg - 12'd1;
        end
        else
        begin
            slice_next.draw_end = end_v[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slice_reg <= slice_next;
        end
    end

    rcs_udiv #(.NW(NW2), .DW(rcs_pkg::LH_W)) u_div_step (
        .clk (clk),
        .en  (en),
        .num (TEX_NUM),
        .den (slice_reg.line_height),
        .quo (q2)
    );

    rcs_delay #(.W($bits(rcs_pkg::slice_t)), .DEPTH(S2)) u_dly_slice (
        .clk  (clk),
        .en   (en),
        .din  (slice_reg),
        .dout (slice_d)
    );

    // texture step and start position
    assign step       = slice_d.degenerate ? 32'hFFFF_FFFF : 32'(q2);
    assign start_full = 47'(slice_d.start_ofs) * 47'(step);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg  <= step;
            start_reg <= slice_d.degenerate ? 32'd0 : start_full[31:0];
            out_reg   <= slice_d;
        end
    end

    assign m_axis_tdata = {2'd0, start_reg, step_reg, col_d, out_reg.draw_end,
                           out_reg.draw_start, out_reg.line_height};
    assign m_axis_tuser = out_reg.degenerate;

endmodule

// ----- hdl/rcs_delay.sv -----
// ----------------------------------------------------------------------------
// rcs_delay
// Enabled shift line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module rcs_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ----- hdl/rcs_udiv.sv -----
// ----------------------------------------------------------------------------
// rcs_udiv
// Pipelined restoring unsigned divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rcs_udiv #(
    parameter int NW = 28,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    localparam int S  = (NW + 1) / 2;
    localparam int PW = 2 * S;

    logic [DW-1:0] rem_reg [S];
    logic [PW-1:0] num_reg [S];
    logic [PW-1:0] quo_reg [S];
    logic [DW-1:0] den_reg [S];

    function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] d);
        logic [DW:0] r2;
        logic [DW:0] diff;
        logic        ge;
        r2   = {r, b};
        ge   = (r2 >= {1'b0, d});
        diff = r2 - {1'b0, d};
        return ge ? {1'b1, diff[DW-1:0]} : {1'b0, r2[DW-1:0]};
    endfunction

    genvar g;
    generate
        for (g = 0; g < S; g++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [PW-1:0] num_in;
            logic [PW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   s1;
            logic [DW:0]   s2;

            if (g == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = PW'(num);
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[g-1];
                assign num_in = num_reg[g-1];
                assign quo_in = quo_reg[g-1];
                assign den_in = den_reg[g-1];
            end

            assign s1 = div_step(rem_in, num_in[PW-1], den_in);
            assign s2 = div_step(s1[DW-1:0], num_in[PW-2], den_in);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= s2[DW-1:0];
                    num_reg[g] <= num_in << 2;
                    quo_reg[g] <= {quo_in[PW-3:0], s1[DW], s2[DW]};
                    den_reg[g] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[S-1][NW-1:0];

endmodule

// ----- hdl/rcs_wall.sv -----
// ----------------------------------------------------------------------------
// rcs_wall
// Wall hit fraction and mirrored texture column, two register stages.
// ----------------------------------------------------------------------------
module rcs_wall #(
    parameter int TEX_SIZE = rcs_pkg::TEX_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic                      hit_side,
    input  logic [31:0]               pos_x,
    input  logic [31:0]               pos_y,
    input  logic [31:0]               ray_dir_x,
    input  logic [31:0]               ray_dir_y,
    input  logic [31:0]               perp_dist,
    output logic [rcs_pkg::COL_W-1:0] tex_col
);

    localparam int TW = $clog2(TEX_SIZE + 1);
    localparam logic [TW-1:0] TEX_V   = TW'(TEX_SIZE);
    localparam logic [TW-1:0] TEX_MAX = TW'(TEX_SIZE - 1);

    logic [31:0] dir;
    logic        neg;
    logic [31:0] mag;
    logic [63:0] prod_full;
    logic        mirror;

    logic [31:0] prod_reg;
    logic        neg_reg;
    logic [15:0] pos_reg;
    logic        mirror_reg;

    logic [31:0]               prod_s;
    logic [31:0]               wall;
    logic [16+TW-1:0]          col_prod;
    logic [TW-1:0]             col_full;
    logic [TW-1:0]             col_sel;
    logic [TW+5:0]             col_ext;
    logic [rcs_pkg::COL_W-1:0] col_reg;

    assign dir       = hit_side ? ray_dir_x : ray_dir_y;
    assign neg       = dir[31];
    assign mag       = neg ? (~dir + 32'd1) : dir;
    assign prod_full = 64'(perp_dist) * 64'(mag);
    assign mirror    = hit_side ? ray_dir_y[31]
                                : (!ray_dir_x[31] && (ray_dir_x != 32'd0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_full[31:0];
            neg_reg    <= neg;
            pos_reg    <= hit_side ? pos_x[15:0] : pos_y[15:0];
            mirror_reg <= mirror;
        end
    end

    assign prod_s   = neg_reg ? (~prod_reg + 32'd1) : prod_reg;
    assign wall     = {pos_reg, 16'd0} + prod_s;
    assign col_prod = (16+TW)'(wall[31:16]) * (16+TW)'(TEX_V);
    assign col_full = col_prod[16+TW-1:16];
    assign col_sel  = mirror_reg ? (TEX_MAX - col_full) : col_full;
    assign col_ext  = {6'd0, col_sel};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_ext[rcs_pkg::COL_W-1:0];
        end
    end

    assign tex_col = col_reg;

endmodule

// ----- tb/column_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// column_checker
// Watches the column input and result streams, computes the expected slice
// and texture values for every accepted column and compares each result
// transfer field by field in order.
// ----------------------------------------------------------------------------
module column_checker #(
    parameter int TEX_SIZE = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           errors,
    output int           pending,
    output int           results_seen,
    output int           degenerate_seen
);

    typedef struct packed {
        logic [15:0] line_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic [5:0]  tex_col;
        logic [31:0] tex_step;
        logic [31:0] tex_start;
        logic        degenerate;
    } column_t;

    logic [11:0] screen_h;
    column_t     expected_cols[$];

    function automatic column_t setup_column(logic side, logic [159:0] d_in,
                                             logic [11:0] h);
        logic [31:0] px, py, dx, dy, distance, dir, mag, step;
        logic [63:0] q, prod, wall, sp;
        logic [15:0] lh, frac;
        logic [31:0] half_h, half_lh;
        int          sv, ev;
        logic        neg;
        column_t     r;
        px       = d_in[31:0];
        py       = d_in[63:32];
        dx       = d_in[95:64];
        dy       = d_in[127:96];
        distance = d_in[159:128];
        if (distance == 0) lh = 16'hFFFF;
        else
        begin
            q  = {36'd0, h, 16'd0} / {32'd0, distance};
            lh = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        r.line_height = lh;
        r.degenerate  = (distance == 0) || (lh == 0);
        half_h  = h / 2;
        half_lh = lh / 2;
        sv = int'(half_h) - int'(half_lh);
        r.draw_start = (sv < 0) ? 12'd0 : sv[11:0];
        ev = int'(half_lh) + int'(half_h);
        if (ev >= int'(h)) ev = int'(h) - 1;
        r.draw_end = (ev < 0) ? 12'd0 : ev[11:0];
        dir  = side ? dx : dy;
        neg  = dir[31];
        mag  = neg ? -dir : dir;
        prod = {32'd0, distance} * {32'd0, mag};
        if (neg) prod = -prod;
        wall = {16'd0, (side ? px : py), 16'd0} + prod;
        frac = wall[31:16];
        r.tex_col = 6'(({48'd0, frac} * TEX_SIZE) >> 16);
        if ((!side && !dx[31] && dx != 0) || (side && dy[31]))
            r.tex_col = 6'(TEX_SIZE - 1 - r.tex_col);
        if (r.degenerate)
        begin
            step = 32'hFFFFFFFF;
            sp   = 0;
        end
        else
        begin
            step = 32'((64'(TEX_SIZE) << 16) / lh);
            sp   = 64'(32'(r.draw_start) + half_lh - half_h) * 64'(step);
        end
        r.tex_step  = step;
        r.tex_start = sp[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_t got, want;
        if (!rst_n)
        begin
            screen_h = 12'd480;
            errors = 0;
            results_seen = 0;
            degenerate_seen = 0;
            expected_cols.delete();
            pending = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_cols.push_back(setup_column(s_axis_tuser[0], s_axis_tdata,
                                                     screen_h));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.line_height = m_axis_tdata[15:0];
                got.draw_start  = m_axis_tdata[27:16];
                got.draw_end    = m_axis_tdata[39:28];
                got.tex_col     = m_axis_tdata[45:40];
                got.tex_step    = m_axis_tdata[77:46];
                got.tex_start   = m_axis_tdata[109:78];
                got.degenerate  = m_axis_tuser[0];
                results_seen++;
                if (got.degenerate) degenerate_seen++;
                if (expected_cols.size() == 0)
                    report("unexpected result", 64'(got), 0);
                else
                begin
                    want = expected_cols.pop_front();
                    if (got.line_height !== want.line_height)
                        report("line_height", got.line_height, want.line_height);
                    if (got.draw_start !== want.draw_start)
                        report("draw_start", got.draw_start, want.draw_start);
                    if (got.draw_end !== want.draw_end)
                        report("draw_end", got.draw_end, want.draw_end);
                    if (got.tex_col !== want.tex_col)
                        report("tex_col", got.tex_col, want.tex_col);
                    if (got.tex_step !== want.tex_step)
                        report("tex_step", got.tex_step, want.tex_step);
                    if (got.tex_start !== want.tex_start)
                        report("tex_start", got.tex_start, want.tex_start);
                    if (got.degenerate !== want.degenerate)
                        report("degenerate", got.degenerate, want.degenerate);
                end
            end
            if (cfg_we)
                screen_h = cfg_wdata;
            pending = expected_cols.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Column setup stimulus: directed corner columns and random columns across
// several screen heights, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY = 28;
    localparam int LIMIT   = 400000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [11:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    int           errors, pending, results_seen, degenerate_seen;
    int           cycles = 0;
    int           columns_sent;

    raycast_column_setup_top DUT (.*);

    column_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result sink: alternate free-flowing and stalling stretches
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60))
            begin
                @(posedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_q(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0008_0000));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(32'h0000_4000, 32'h0020_0000));
        endcase
    endfunction

    task automatic send_column(logic side, logic [31:0] px, logic [31:0] py,
                               logic [31:0] dx, logic [31:0] dy, logic [31:0] dist_q);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= side;
        s_axis_tdata  <= {dist_q, dy, dx, py, px};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        columns_sent++;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_height(logic [11:0] h);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            repeat ($urandom_range(1, 20))
            begin
                send_column(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                            rand_q($urandom_range(0, 3)), rand_q($urandom_range(0, 3)),
                            ($urandom_range(0, 30) == 0) ? 32'd0
                                : rand_q($urandom_range(0, 3)));
                n++;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [11:0] heights[5];
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        columns_sent = 0;
        heights = '{12'd1, 12'd4095, 12'd0, 12'd200, 12'd480};
        @(posedge rst_n);
        @(posedge clk);
        // corner columns at the reset height
        send_column(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0001_0000, 32'h0000_8000,
                    32'h0001_0000);
        send_column(1'b1, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_0000, 32'hFFFF_8000,
                    32'h0002_0000);
        send_column(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF);
        send_column(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF);
        send_column(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_column(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_column(1'b0, 32'h0, 32'h0003_0000, 32'h0, 32'hFFFF_0001, 32'h0000_0001);
        send_column(1'b1, 32'h0000_1234, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0000_8000);
        send_column(1'b0, 32'h0005_0000, 32'h0005_FFFF, 32'h8000_0000, 32'h0001_0000,
                    32'h01E0_0000);
        send_column(1'b1, 32'h0005_FFFF, 32'h0, 32'h0000_0001, 32'h8000_0001,
                    32'h01E0_0001);
        send_column(1'b0, 32'h0, 32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_0100);
        send_column(1'b1, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0000_FFFF);
        s_axis_tvalid <= 1'b0;
        random_phase(200);
        // hold until everything is back
        drain();
        random_phase(100);
        foreach (heights[i])
        begin
            set_height(heights[i]);
            send_column(1'b0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_0001);
            send_column(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
            random_phase(100);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain();
        $display("%0d columns sent, %0d results checked, %0d degenerate",
                 columns_sent, results_seen, degenerate_seen);
        $display("screen heights 480, 1, 4095, 0, 200 and 480 again were exercised");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
